>>> rtl/cdd_pkg.sv
// Shared types, constants and calendar tables for the date difference unit.
package cdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DIFF_W  = 23;
	localparam int ORD_W   = 22;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Reciprocal of 25 scaled by 2^16, rounded down
	localparam logic [11:0] RECIP_25 = 12'd2621;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;   // capture input word
		logic mul;    // reciprocal multiply
		logic quo;    // quotient correction
		logic sum;    // ordinal accumulation
		logic diff;   // final subtract and result capture
		logic sel;    // 0: first date, 1: second date
	} cdd_cmd_t;

	// Days in month for a common year; 0 for bad month codes
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	// Days in the year before the first of month m (common year)
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cdd_in_if.sv
// Request channel: a pair of dates with valid/ready handshake.
interface cdd_in_if;
	import cdd_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  first_year;
	logic [MONTH_W-1:0] first_month;
	logic [DAY_W-1:0]   first_day;
	logic [YEAR_W-1:0]  second_year;
	logic [MONTH_W-1:0] second_month;
	logic [DAY_W-1:0]   second_day;

	modport source (output valid, first_year, first_month, first_day,
		second_year, second_month, second_day, input ready);
	modport sink (input valid, first_year, first_month, first_day,
		second_year, second_month, second_day, output ready);
endinterface

>>> rtl/cdd_out_if.sv
// Result channel: signed day difference and invalid flag.
interface cdd_out_if;
	import cdd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DIFF_W-1:0] day_difference;
	logic                     date_invalid;

	modport source (output valid, day_difference, date_invalid, input ready);
	modport sink (input valid, day_difference, date_invalid, output ready);
endinterface

>>> rtl/cdd_ctrl.sv
// Sequencer: steps the datapath through both dates and holds the result word.
module cdd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cdd_pkg::cdd_cmd_t cmd
);
	import cdd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_QUO,
		ST_SUM,
		ST_DIFF,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   sel_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	// Command decode
	always_comb begin
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.mul  = (state_q == ST_MUL);
		cmd.quo  = (state_q == ST_QUO);
		cmd.sum  = (state_q == ST_SUM);
		cmd.diff = (state_q == ST_DIFF);
	end

	// State and date select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					sel_q <= 1'b0;
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_QUO;
				ST_QUO:  state_q <= ST_SUM;
				ST_SUM: begin
					// second pass for the ending date
					if (sel_q) begin
						state_q <= ST_DIFF;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DIFF: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/cdd_datapath.sv
// Datapath: day ordinal of each date via a shared divide-by-100 unit, then the difference.
module cdd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdd_pkg::cdd_cmd_t                 cmd,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic [cdd_pkg::YEAR_W-1:0]        first_year,
	input  logic [cdd_pkg::MONTH_W-1:0]       first_month,
	input  logic [cdd_pkg::DAY_W-1:0]         first_day,
	input  logic [cdd_pkg::YEAR_W-1:0]        second_year,
	input  logic [cdd_pkg::MONTH_W-1:0]       second_month,
	input  logic [cdd_pkg::DAY_W-1:0]         second_day,
	output logic signed [cdd_pkg::DIFF_W-1:0] day_difference,
	output logic                              date_invalid
);
	import cdd_pkg::*;

	logic                     include_q;
	logic [YEAR_W-1:0]        y1_q, y2_q;
	logic [MONTH_W-1:0]       m1_q, m2_q;
	logic [DAY_W-1:0]         d1_q, d2_q;
	logic [23:0]              prod_q;
	logic [7:0]               yq_q;
	logic [ORD_W-1:0]         ord1_q, ord2_q;
	logic                     ok1_q, ok2_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic                     inv_q;

	logic [YEAR_W-1:0]  y;
	logic [MONTH_W-1:0] m;
	logic [DAY_W-1:0]   d;
	logic [11:0]        x;
	logic [7:0]         q_est;
	logic [12:0]        rem;
	logic [7:0]         q_fix;
	logic               c100, lp;
	logic [YEAR_W-1:0]  p;
	logic [7:0]         p100;
	logic [ORD_W-1:0]   ord;
	logic [DAY_W-1:0]   dim;
	logic               ok;
	logic signed [DIFF_W-1:0] raw_diff;
	logic signed [DIFF_W-1:0] adj_diff;

	// Date select for the shared unit
	assign y = cmd.sel ? y2_q : y1_q;
	assign m = cmd.sel ? m2_q : m1_q;
	assign d = cmd.sel ? d2_q : d1_q;
	assign x = y[YEAR_W-1:2];

	// Quotient estimate y/100 = (y/4)/25, off by at most one low
	assign q_est = prod_q[23:16];
	assign rem   = 13'(x) - 13'(q_est) * 13'd25;
	assign q_fix = (rem >= 13'd25) ? q_est + 8'd1 : q_est;

	// Leap rule and ordinal from the corrected quotient
	always_comb begin
		c100 = (15'(y) == 15'(yq_q) * 15'd100);
		lp   = c100 ? (yq_q[1:0] == 2'b00) : (y[1:0] == 2'b00);
		p    = y - 14'd1;
		p100 = yq_q - 8'(c100);
		ord  = 22'(p) * 22'd365 + 22'(p[YEAR_W-1:2]) - 22'(p100) + 22'(p100[7:2])
			+ 22'(days_before(m)) + 22'(lp && (m > MONTH_FEB)) + 22'(d);
		dim  = month_len(m) + 5'(lp && (m == MONTH_FEB));
		ok   = (y != '0) && (y <= YEAR_MAX) && (m != '0) && (m <= MONTH_DEC)
			&& (d != '0) && (d <= dim);
	end

	// Difference with optional end-day count
	assign raw_diff = signed'({1'b0, ord2_q}) - signed'({1'b0, ord1_q});
	assign adj_diff = !include_q ? raw_diff :
		(raw_diff < 0) ? raw_diff - 23'sd1 : raw_diff + 23'sd1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_q <= 1'b0;
		end else if (cfg_we) begin
			include_q <= cfg_wdata;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y1_q <= first_year;
			m1_q <= first_month;
			d1_q <= first_day;
			y2_q <= second_year;
			m2_q <= second_month;
			d2_q <= second_day;
		end
		if (cmd.mul) prod_q <= 24'(x) * 24'(RECIP_25);
		if (cmd.quo) yq_q <= q_fix;
		if (cmd.sum) begin
			if (cmd.sel) begin
				ord2_q <= ord;
				ok2_q  <= ok;
			end else begin
				ord1_q <= ord;
				ok1_q  <= ok;
			end
		end
		if (cmd.diff) begin
			diff_q <= (ok1_q && ok2_q) ? adj_diff : '0;
			inv_q  <= !(ok1_q && ok2_q);
		end
	end

	assign day_difference = diff_q;
	assign date_invalid   = inv_q;
endmodule

>>> rtl/calendar_date_difference_unit.sv
// After a pair of dates is accepted, the shared multiply / correct / accumulate
// unit runs three steps per date, first date then second, then one subtract,
// and the result word is offered until it is taken.
// A new word is taken only after the previous result has been taken.
// Reset (arst_n, asynchronous, active low) returns the sequencer to idle and
// clears include_end_day; no result is pending after reset.
module calendar_date_difference_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	cdd_in_if.sink    req,
	cdd_out_if.source rsp
);
	import cdd_pkg::*;

	cdd_cmd_t cmd;

	cdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	cdd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.first_year     (req.first_year),
		.first_month    (req.first_month),
		.first_day      (req.first_day),
		.second_year    (req.second_year),
		.second_month   (req.second_month),
		.second_day     (req.second_day),
		.day_difference (rsp.day_difference),
		.date_invalid   (rsp.date_invalid)
	);
endmodule

>>> tb/tb_calendar_date_difference_unit.sv
// Self-checking testbench for the calendar date difference unit.
module tb_calendar_date_difference_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cdd_pkg::*;

	localparam int MAX_CYCLES   = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_PAIRS  = 500;
	localparam int REPORT_LIMIT = 10;

	// One request word: two dates
	typedef struct packed {
		logic [YEAR_W-1:0]  y1;
		logic [MONTH_W-1:0] m1;
		logic [DAY_W-1:0]   d1;
		logic [YEAR_W-1:0]  y2;
		logic [MONTH_W-1:0] m2;
		logic [DAY_W-1:0]   d2;
	} date_pair_t;

	// Predicted result word, with the dates kept for reporting
	typedef struct {
		date_pair_t               dates;
		logic signed [DIFF_W-1:0] span;
		logic                     invalid;
	} day_span_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

	// Calendar arithmetic and the queue of day spans still owed by the block
	class day_span_checker;
		bit        end_day;
		int        errors;
		day_span_t owed_spans[$];

		static function bit is_leap(int y);
			return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
		endfunction

		static function int month_days(int m, int y);
			int n;
			case (m)
				1, 3, 5, 7, 8, 10, 12: n = 31;
				4, 6, 9, 11:           n = 30;
				2:                     n = is_leap(y) ? 29 : 28;
				default:               n = 0;
			endcase
			return n;
		endfunction

		static function bit well_formed(int y, int m, int d);
			return (y >= 1) && (y <= 9999) && (m >= 1) && (m <= 12) &&
				(d >= 1) && (d <= month_days(m, y));
		endfunction

		// Day number counted from 0001-01-01 as day 1
		static function int day_number(int y, int m, int d);
			int p;
			int n;
			p = y - 1;
			n = p * 365 + p / 4 - p / 100 + p / 400;
			for (int i = 1; i < m; i++)
				n += month_days(i, y);
			return n + d;
		endfunction

		function int pending();
			return owed_spans.size();
		endfunction

		// Accepted request word: work out the span it owes
		function void note_dates(date_pair_t p);
			day_span_t s;
			int        span;
			s.dates = p;
			if (!well_formed(int'(p.y1), int'(p.m1), int'(p.d1)) ||
				!well_formed(int'(p.y2), int'(p.m2), int'(p.d2))) begin
				s.span = '0;
				s.invalid = 1'b1;
			end else begin
				span = day_number(int'(p.y2), int'(p.m2), int'(p.d2))
					- day_number(int'(p.y1), int'(p.m1), int'(p.d1));
				if (end_day)
					span = (span < 0) ? span - 1 : span + 1;
				s.span = DIFF_W'(span);
				s.invalid = 1'b0;
			end
			owed_spans.push_back(s);
		endfunction

		// Accepted result word: compare with the oldest owed span
		function void check_span(logic signed [DIFF_W-1:0] got_span, logic got_invalid);
			day_span_t s;
			if (owed_spans.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("ERROR: unexpected result word diff %0d invalid %0b",
						got_span, got_invalid);
				errors++;
				return;
			end
			s = owed_spans.pop_front();
			if (got_span !== s.span || got_invalid !== s.invalid) begin
				if (errors < REPORT_LIMIT)
					$display("ERROR: %0d-%0d-%0d to %0d-%0d-%0d: exp %0d/%0b got %0d/%0b",
						s.dates.y1, s.dates.m1, s.dates.d1, s.dates.y2, s.dates.m2,
						s.dates.d2, s.span, s.invalid, got_span, got_invalid);
				errors++;
			end
		endfunction

		function void count_leftovers();
			if (owed_spans.size() != 0) begin
				if (errors < REPORT_LIMIT)
					$display("ERROR: %0d result words never arrived", owed_spans.size());
				errors += owed_spans.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	cdd_in_if  req_if();
	cdd_out_if rsp_if();

	calendar_date_difference_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	day_span_checker spans = new();

	bit hold_request;
	int cycle_count;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Watch both channels at the clock edge
	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready)
			spans.note_dates(date_pair_t'{req_if.first_year, req_if.first_month,
				req_if.first_day, req_if.second_year, req_if.second_month,
				req_if.second_day});
		if (arst_n && rsp_if.valid && rsp_if.ready)
			spans.check_span(rsp_if.day_difference, rsp_if.date_invalid);
	end

	// Result side: stall pattern plus the occasional long hold-off
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  rsp_if.ready <= 1'b1;
					RX_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
					default:  rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic date_pair_t make_pair(int y1, int m1, int d1, int y2, int m2, int d2);
		date_pair_t p;
		p.y1 = YEAR_W'(y1);
		p.m1 = MONTH_W'(m1);
		p.d1 = DAY_W'(d1);
		p.y2 = YEAR_W'(y2);
		p.m2 = MONTH_W'(m2);
		p.d2 = DAY_W'(d2);
		return p;
	endfunction

	// Mostly well-formed pairs, some near each other, some broken, some raw noise
	function automatic date_pair_t random_pair();
		date_pair_t  p;
		logic [63:0] noise;
		int          kind;
		int          y1;
		int          y2;
		int          m1;
		int          m2;
		kind = $urandom_range(0, 99);
		if (kind >= 92) begin
			noise = {$urandom, $urandom};
			p = noise[$bits(date_pair_t)-1:0];
			return p;
		end
		case ($urandom_range(0, 9))
			0:       y1 = ($urandom_range(0, 1) != 0) ? 1 : 9999;
			1:       y1 = 4 * int'($urandom_range(1, 2499));
			default: y1 = $urandom_range(1, 9999);
		endcase
		if (kind >= 70) begin
			y2 = y1 + int'($urandom_range(0, 4)) - 2;
			if (y2 < 1)
				y2 = 1;
			if (y2 > 9999)
				y2 = 9999;
		end else begin
			y2 = $urandom_range(1, 9999);
		end
		m1 = $urandom_range(1, 12);
		m2 = $urandom_range(1, 12);
		p = make_pair(y1, m1, $urandom_range(1, day_span_checker::month_days(m1, y1)),
			y2, m2, $urandom_range(1, day_span_checker::month_days(m2, y2)));
		// Break one field of an otherwise good pair
		if (kind >= 85) begin
			case ($urandom_range(0, 5))
				0: p.d1 = DAY_W'(day_span_checker::month_days(m1, y1) + 1);
				1: p.d2 = '0;
				2: p.m1 = '0;
				3: p.m2 = MONTH_W'($urandom_range(13, 15));
				4: p.y1 = '0;
				default: p.y2 = YEAR_W'($urandom_range(10000, 16383));
			endcase
		end
		return p;
	endfunction

	// Offer one word and hold it until it is taken
	task automatic send_pair(input date_pair_t p);
		req_if.valid <= 1'b1;
		req_if.first_year <= p.y1;
		req_if.first_month <= p.m1;
		req_if.first_day <= p.d1;
		req_if.second_year <= p.y2;
		req_if.second_month <= p.m2;
		req_if.second_day <= p.d2;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	task automatic idle_input(input int cycles);
		req_if.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_spans();
		while (spans.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Register write, only once the block has gone quiet
	task automatic write_end_day(input bit v);
		drain_spans();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		spans.end_day = v;
	endtask

	task automatic run_directed();
		date_pair_t edge_pairs[$];
		edge_pairs.push_back(make_pair(1, 1, 1, 9999, 12, 31));
		edge_pairs.push_back(make_pair(9999, 12, 31, 1, 1, 1));
		edge_pairs.push_back(make_pair(2024, 5, 17, 2024, 5, 17));
		edge_pairs.push_back(make_pair(1999, 12, 31, 2000, 1, 1));
		edge_pairs.push_back(make_pair(2000, 1, 1, 1999, 12, 31));
		edge_pairs.push_back(make_pair(2000, 2, 29, 2001, 3, 1));
		edge_pairs.push_back(make_pair(2004, 2, 29, 2004, 3, 1));
		edge_pairs.push_back(make_pair(1900, 2, 28, 1900, 3, 1));
		edge_pairs.push_back(make_pair(1900, 2, 29, 1901, 1, 1));
		edge_pairs.push_back(make_pair(2003, 1, 1, 2003, 2, 29));
		edge_pairs.push_back(make_pair(2010, 0, 5, 2011, 1, 1));
		edge_pairs.push_back(make_pair(2010, 1, 5, 2011, 13, 1));
		edge_pairs.push_back(make_pair(2010, 15, 5, 2011, 1, 1));
		edge_pairs.push_back(make_pair(2010, 1, 0, 2011, 1, 1));
		edge_pairs.push_back(make_pair(2010, 4, 31, 2011, 1, 1));
		edge_pairs.push_back(make_pair(2010, 1, 31, 2011, 12, 31));
		edge_pairs.push_back(make_pair(0, 1, 1, 2011, 1, 1));
		edge_pairs.push_back(make_pair(1, 1, 1, 10000, 1, 1));
		edge_pairs.push_back(make_pair(16383, 15, 31, 16383, 15, 31));
		edge_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
		edge_pairs.push_back(make_pair(1600, 12, 31, 1601, 1, 1));
		foreach (edge_pairs[i])
			send_pair(edge_pairs[i]);
		idle_input(1);
	endtask

	// Random bursts; the first burst runs into a long result hold-off
	task automatic run_random(input int count);
		int sent;
		int burst;
		hold_request = 1'b1;
		for (int i = 0; i < 24; i++)
			send_pair(random_pair());
		sent = 24;
		while (sent < count) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_pair(random_pair());
				sent++;
			end
			idle_input(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12));
		end
		idle_input(1);
	endtask

	// Main sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.first_year <= '0;
		req_if.first_month <= '0;
		req_if.first_day <= '0;
		req_if.second_year <= '0;
		req_if.second_month <= '0;
		req_if.second_day <= '0;
		hold_request = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// include_end_day still at its reset value here
		run_directed();
		write_end_day(1'b1);
		run_directed();

		write_end_day(1'b0);
		run_random(PHASE_PAIRS);
		write_end_day(1'b1);
		run_random(PHASE_PAIRS);
		write_end_day(1'b0);
		run_random(PHASE_PAIRS);
		write_end_day(1'b1);
		run_random(PHASE_PAIRS);

		drain_spans();
		spans.count_leftovers();
		if (spans.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
